FILE: hdl/otd_pkg.sv
// shared types and constants for the odd trial-division prime test core
// no dependencies; used by otd_rem_unit and odd_trial_division_prime_test_core
package otd_pkg;

  // width of the candidate field on the port
  localparam int unsigned CAND_WIDTH = 32;
  // default working width of the test
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // first odd divisor tried and the step between divisors
  localparam int unsigned FIRST_DIV = 3;
  localparam int unsigned DIV_STEP  = 2;

  // status from the remainder unit to the sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } rem_sts_t;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DIVIDE = 3'b100
  } seq_state_e;

endpackage

FILE: hdl/odd_trial_division_prime_test_core.sv
// odd trial-division prime test: sequencer, divisor/square tracking, result register
// depends on otd_pkg and otd_rem_unit
//
// usage:
//   command channel: drive candidate_i and raise start; the candidate is taken
//   at a rising edge where start is high and busy is low. busy stays high
//   while the test runs and no new command is taken.
//   result channel: done_o is high for exactly one cycle with is_prime_o valid;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   busy falls in the same cycle done_o rises, so the next command can be
//   taken right at the result cycle.
// operation:
//   odd divisors d = 3, 5, 7, ... are tried while d*d <= candidate. each
//   divisor goes through a bound-check state, the bit-serial remainder unit
//   (one dividend bit per cycle) and a registered status hand-back to the
//   sequencer. a prime verdict follows the last bound check and a composite
//   one the first zero remainder. up to about 32768 divisors are tried for
//   32-bit candidates.
// reset: the sequencer returns to idle, no result is pending.
module odd_trial_division_prime_test_core #(
  parameter int unsigned VALUE_WIDTH = otd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [otd_pkg::CAND_WIDTH-1:0]  candidate_i,
  output logic                            done_o,
  output logic                            is_prime_o
);

  localparam int unsigned SqW = VALUE_WIDTH + 2;

  otd_pkg::seq_state_e state_q, state_d;
  otd_pkg::rem_sts_t   rem_sts;

  logic [VALUE_WIDTH-1:0] cand_n;
  logic [VALUE_WIDTH-1:0] n_q, n_d;
  logic [VALUE_WIDTH-1:0] d_q, d_d;
  logic [SqW-1:0]         sq_q, sq_d;
  logic                   done_q, done_d;
  logic                   prime_q, prime_d;
  logic                   div_start;

  // keep only the low VALUE_WIDTH bits of the candidate, zero-extended when VALUE_WIDTH is wider
  if (VALUE_WIDTH >= otd_pkg::CAND_WIDTH) begin : g_ext
    assign cand_n = VALUE_WIDTH'(candidate_i);
  end else begin : g_trunc
    assign cand_n = candidate_i[VALUE_WIDTH-1:0];
  end

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    d_d       = d_q;
    sq_d      = sq_q;
    done_d    = 1'b0;
    prime_d   = prime_q;
    div_start = 1'b0;
    case (state_q)
      otd_pkg::ST_IDLE: begin
        if (start) begin
          n_d     = cand_n;
          d_d     = VALUE_WIDTH'(otd_pkg::FIRST_DIV);
          sq_d    = SqW'(otd_pkg::FIRST_DIV * otd_pkg::FIRST_DIV);
          state_d = otd_pkg::ST_CHECK;
        end
      end
      otd_pkg::ST_CHECK: begin
        if (sq_q > {2'b00, n_q}) begin
          // no divisor left under the square root
          done_d  = 1'b1;
          prime_d = 1'b1;
          state_d = otd_pkg::ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = otd_pkg::ST_DIVIDE;
        end
      end
      otd_pkg::ST_DIVIDE: begin
        if (rem_sts.done) begin
          if (rem_sts.rem_zero) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
            state_d = otd_pkg::ST_IDLE;
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            sq_d    = sq_q + {d_q, 2'b00} + SqW'(otd_pkg::DIV_STEP * otd_pkg::DIV_STEP);
            d_d     = d_q + VALUE_WIDTH'(otd_pkg::DIV_STEP);
            state_d = otd_pkg::ST_CHECK;
          end
        end
      end
      default: begin
        state_d = otd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= otd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
  end

  otd_rem_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .sts_o      (rem_sts)
  );

  assign busy       = (state_q != otd_pkg::ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

  // a result only shows once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // a taken command always starts the test
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but sequencer stayed idle");

  // divisor stays odd throughout the test
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> d_q[0])
    else $error("even divisor in use");

  // remainder unit only finishes while the sequencer waits for it
  a_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sts.done |-> (state_q == otd_pkg::ST_DIVIDE))
    else $error("remainder done outside divide state");

  // a composite verdict comes straight from a zero remainder
  a_comp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_prime_o) |-> $past(rem_sts.done && rem_sts.rem_zero))
    else $error("composite verdict without zero remainder");

endmodule

FILE: hdl/otd_rem_unit.sv
// bit-serial restoring remainder unit: one dividend bit per cycle
// depends on otd_pkg (rem_sts_t)
module otd_rem_unit #(
  parameter int unsigned VALUE_WIDTH = otd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output otd_pkg::rem_sts_t      sts_o
);

  localparam int unsigned CntW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(VALUE_WIDTH - 1);

  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH:0]   trial;

  // divisor is held stable by the sequencer while the unit runs
  assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      dvd_d = {dvd_q[VALUE_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = VALUE_WIDTH'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[VALUE_WIDTH-1:0];
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastCnt) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.rem_zero = (rem_q == '0);

endmodule

FILE: sim/testbench.sv
// testbench for odd_trial_division_prime_test_core: directed table, then random candidates
// depends on otd_pkg and the core rtl; verdicts come from the directed table or a local trial-division predictor
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned VALUE_WIDTH    = otd_pkg::VALUE_WIDTH_DEF;
  localparam int          RAND_ITEMS     = 80;
  // the last random commands go out back to back
  localparam int          CALM_TAIL      = 20;
  localparam int          DRAIN_CYCLES   = 40;
  // bound on cycles with no transfer; it must cover the slowest directed candidate
  localparam int          WATCHDOG_LIMIT = 300000;

  typedef struct packed {
    logic [otd_pkg::CAND_WIDTH-1:0] cand;
    logic                           fixed;
    logic                           fixed_verdict;
  } dir_row_t;

  typedef struct packed {
    logic [otd_pkg::CAND_WIDTH-1:0] cand;
    logic                           verdict;
  } verdict_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{32'd0,          1'b1, 1'b1},
    '{32'd1,          1'b1, 1'b1},
    '{32'd2,          1'b1, 1'b1},
    '{32'd3,          1'b1, 1'b1},
    '{32'd4,          1'b1, 1'b1},
    '{32'd5,          1'b1, 1'b1},
    '{32'd6,          1'b1, 1'b1},
    '{32'd7,          1'b1, 1'b1},
    '{32'd8,          1'b1, 1'b1},
    '{32'd9,          1'b1, 1'b0},  // divisor squared equals the candidate
    '{32'd16,         1'b1, 1'b1},  // even, no odd factor in range
    '{32'd18,         1'b1, 1'b0},  // even with odd factor 3
    '{32'd25,         1'b1, 1'b0},
    '{32'd49,         1'b1, 1'b0},
    '{32'd121,        1'b1, 1'b0},
    '{32'd97,         1'b0, 1'b0},
    '{32'd65537,      1'b0, 1'b0},
    '{32'd16777213,   1'b0, 1'b0},
    '{32'hFFFF_FFFF,  1'b1, 1'b0},
    '{32'hFFFF_FFF9,  1'b1, 1'b0},
    '{32'h5555_5555,  1'b1, 1'b0},
    '{32'hAAAA_AAAA,  1'b1, 1'b0},
    '{32'h8000_0001,  1'b1, 1'b0}
  };

  logic                           clk;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [otd_pkg::CAND_WIDTH-1:0] candidate_i;
  logic                           done_o;
  logic                           is_prime_o;

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       commands_sent;
  int       results_seen;
  int       primes_seen;
  int       idle_cycles;

  odd_trial_division_prime_test_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .candidate_i(candidate_i),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // 1 when no odd d >= 3 with d*d <= n divides n
  function automatic logic predict_verdict(input logic [otd_pkg::CAND_WIDTH-1:0] cand);
    longint unsigned n;
    longint unsigned d;
    longint unsigned mask;
    if (VALUE_WIDTH >= 64) mask = '1;
    else mask = (64'd1 << VALUE_WIDTH) - 64'd1;
    n = longint'(cand) & mask;
    d = otd_pkg::FIRST_DIV;
    while (d <= n / d) begin
      if (n % d == 0) return 1'b0;
      d += otd_pkg::DIV_STEP;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // drive one command and record its verdict once the transfer happens
  task automatic issue_candidate(input logic [otd_pkg::CAND_WIDTH-1:0] cand,
                                 input logic fixed, input logic fixed_verdict,
                                 input int gap);
    verdict_t entry;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    candidate_i = cand;
    do @(posedge clk); while (busy);
    @(negedge clk);
    entry.cand    = cand;
    entry.verdict = fixed ? fixed_verdict : predict_verdict(cand);
    pending_verdicts.push_back(entry);
    commands_sent++;
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 12)) : 0;
  endfunction

  function automatic logic [otd_pkg::CAND_WIDTH-1:0] random_candidate();
    int unsigned sel;
    int unsigned a;
    int unsigned b;
    int unsigned m;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      return $urandom_range(3, 4095) | 32'd1;
    end else if (sel < 60) begin
      // odd products probe the square-root bound
      a = $urandom_range(1, 127) * 2 + 1;
      b = $urandom_range(1, 127) * 2 + 1;
      return a * b;
    end else if (sel < 80) begin
      // full-width value with a small odd factor keeps the test short
      a = $urandom_range(1, 30) * 2 + 1;
      m = $urandom;
      return m - (m % a);
    end else if (sel < 90) begin
      return $urandom_range(4097, 1048575) | 32'd1;
    end else begin
      return $urandom_range(0, 4095);
    end
  endfunction

  // result check
  always @(posedge clk) begin
    verdict_t entry;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        entry = pending_verdicts.pop_front();
        if (is_prime_o !== entry.verdict)
          report_mismatch($sformatf("candidate %0d: is_prime %b, predicted %b",
                                    entry.cand, is_prime_o, entry.verdict));
        if (entry.verdict) primes_seen++;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_verdicts.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    mismatches    = 0;
    commands_sent = 0;
    results_seen  = 0;
    primes_seen   = 0;
    idle_cycles   = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    candidate_i   = '0;
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      issue_candidate(DIR_TABLE[i].cand, DIR_TABLE[i].fixed, DIR_TABLE[i].fixed_verdict,
                      pick_gap());

    for (int i = 0; i < RAND_ITEMS; i++)
      issue_candidate(random_candidate(), 1'b0, 1'b0,
                      (i < RAND_ITEMS - CALM_TAIL) ? pick_gap() : 0);

    start = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d candidates (%0d from the directed table), got %0d verdicts",
             commands_sent, DIR_ROWS, results_seen);
    $display("verdicts: %0d prime, %0d composite", primes_seen, results_seen - primes_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/otd_pkg.sv
hdl/otd_rem_unit.sv
hdl/odd_trial_division_prime_test_core.sv
sim/testbench.sv
